>>> rtl/lms_pkg.sv
// Shared constants and types for the locomotive momentum step core.
package lms_pkg;

  localparam int unsigned FullScale = 25600;
  localparam int unsigned StandstillBand = 128;

  // Configuration register indexes
  localparam logic [2:0] CfgSpinup      = 3'd0;
  localparam logic [2:0] CfgAirDrag     = 3'd1;
  localparam logic [2:0] CfgRollDrag    = 3'd2;
  localparam logic [2:0] CfgBrakeGain   = 3'd3;
  localparam logic [2:0] CfgPowerGain   = 3'd4;
  localparam logic [2:0] CfgSmokeThrGain = 3'd5;
  localparam logic [2:0] CfgSmokeWrkGain = 3'd6;

  // Engine commands
  localparam logic [1:0] CmdStart = 2'd1;
  localparam logic [1:0] CmdStop  = 2'd2;

  // Multiplier request to the serial unit
  typedef struct packed {
    logic        start;
    logic [39:0] mcand;
    logic [39:0] mplier;
  } mul_req_t;

endpackage

>>> rtl/lms_serial_mul.sv
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle.
module lms_serial_mul
  import lms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mul_req_t    req_i,
  output logic        done_o,
  output logic [79:0] prod_o
);

  logic [79:0] acc_q, acc_d;
  logic [79:0] mc_q, mc_d;
  logic [39:0] mp_q, mp_d;
  logic        busy_q, busy_d;

  always_comb begin
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    busy_d = busy_q;
    if (req_i.start) begin
      acc_d  = '0;
      mc_d   = {40'd0, req_i.mcand};
      mp_d   = req_i.mplier;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (mp_q[0]) acc_d = acc_q + mc_q;
      mc_d = {mc_q[78:0], 1'b0};
      mp_d = {1'b0, mp_q[39:1]};
      if (mp_q[39:1] == '0) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  // last step: independent of a new request, so a follow-on start may use it
  assign done_o = busy_q && (mp_q[39:1] == '0);
  assign prod_o = mp_q[0] ? acc_q + mc_q : acc_q;

endmodule

>>> rtl/lms_isqrt.sv
// Digit-by-digit integer square root: one result bit per cycle.
module lms_isqrt
  import lms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] rad_i,
  output logic        done_o,
  output logic [19:0] root_o
);

  logic [39:0] rem_q, rem_d;
  logic [39:0] rad_q, rad_d;
  logic [19:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [41:0] trial;
  logic [41:0] rem_sh;

  always_comb begin
    rem_d  = rem_q;
    rad_d  = rad_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_sh = {rem_q, rad_q[39:38]};
    trial  = {20'd0, root_q, 2'b01};
    if (start_i) begin
      rem_d  = '0;
      rad_d  = rad_i;
      root_d = '0;
      cnt_d  = 5'd19;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[37:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = 40'(rem_sh - trial);
        root_d = {root_q[18:0], 1'b1};
      end else begin
        rem_d  = rem_sh[39:0];
        root_d = {root_q[18:0], 1'b0};
      end
      if (cnt_q == '0) busy_d = 1'b0;
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    rad_q  <= rad_d;
    root_q <= root_d;
    cnt_q  <= cnt_d;
  end

  assign done_o = busy_q && !busy_d && !start_i;
  assign root_o = root_d;

endmodule

>>> rtl/locomotive_momentum_step_core.sv
// Top level of the locomotive momentum step core.
//
//  channel   direction  fields
//  s_axis    in         tdata: throttle, brake, reverser, master, engine cmd
//  m_axis    out        tdata: speed, engine, smoke, engine running
//  cfg       in         write enable, index, 24-bit data
//
// One tick at a time: each accepted tick runs up to six products on the
// shift-and-add multiplier, which stops after the highest set multiplier bit,
// and up to two square roots; the power and throttle smoke steps are skipped
// when not needed, and all smoke steps when the engine is off. The input is
// ready again from the cycle the result appears. The result waits in an output
// register; a new tick is taken while it waits, and the following result holds
// in the last state until the register frees. Reset clears the state to
// engine off, zero levels, and the registers to their defaults.
module locomotive_momentum_step_core
  import lms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [14:0] throttle_level, [29:15] brake_level, [31:30] reverser_dir,
  // [32] master_switch, [34:33] engine_cmd, [39:35] zero
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] speed_level, [30:16] engine_level, [45:31] smoke_level,
  // [46] engine_running, [47] zero
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  typedef enum logic [3:0] {
    StIdle, StAir1, StAir2, StBrake, StDrag, StPow, StPowSq,
    StSmk1, StSmk2, StSmkSq, StSmk3, StDone
  } state_e;

  state_e state_q;

  // configuration registers
  logic [14:0] spinup_q, roll_q;
  logic [23:0] air_q, brk_gain_q, pow_q, sthr_q, swrk_q;

  // tick state
  logic        eon_q;
  logic [14:0] eng_q;
  logic signed [16:0] spd_q;

  // per-tick working registers
  logic [14:0] thr_q, brk_q;
  logic [1:0]  dir_q;
  logic        master_q;
  logic [39:0] drag_q;
  logic [39:0] smk_q;

  logic        out_valid_q;
  logic [47:0] out_data_q;

  mul_req_t    mreq;
  logic        mdone;
  logic [79:0] mprod;
  logic        sq_start, sq_done;
  logic [39:0] sq_rad;
  logic [19:0] sq_root;

  lms_serial_mul u_mul (
    .clk_i, .rst_ni, .req_i(mreq), .done_o(mdone), .prod_o(mprod)
  );

  lms_isqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_rad),
    .done_o(sq_done), .root_o(sq_root)
  );

  // front-end decode of the accepted item
  logic        acc;
  logic [14:0] in_thr;
  logic [1:0]  in_cmd;
  logic        in_master;
  logic        eon_new;
  logic signed [17:0] e_tmp;
  logic [14:0] eng_new;
  logic [16:0] mag;

  assign acc       = s_axis_tvalid && s_axis_tready;
  assign in_thr    = s_axis_tdata[14:0];
  assign in_master = s_axis_tdata[32];
  assign in_cmd    = s_axis_tdata[34:33];
  assign mag       = spd_q[16] ? 17'(-spd_q) : 17'(spd_q);

  always_comb begin
    eon_new = eon_q;
    if (in_cmd == CmdStart) eon_new = in_master;
    else if (in_cmd == CmdStop) eon_new = 1'b0;
    if (!in_master) eon_new = 1'b0;
    e_tmp = 18'(eng_q);
    if (eon_new) begin
      // lower deadband edge kept on the left so no side goes negative
      if ({2'b0, eng_q, 1'b0} + 18'(spinup_q) < 18'({in_thr, 1'b0}))
        e_tmp = 18'(eng_q) + 18'(spinup_q);
      else if ({2'b0, eng_q, 1'b0} > 18'({in_thr, 1'b0}) + 18'(spinup_q))
        e_tmp = 18'(eng_q) - 18'(spinup_q);
    end else begin
      e_tmp = 18'(eng_q) - 18'(spinup_q);
    end
    if (e_tmp < 0) eng_new = '0;
    else if (e_tmp > 18'(FullScale)) eng_new = 15'(FullScale);
    else eng_new = e_tmp[14:0];
  end

  // drag applied to speed, then push candidate
  logic signed [41:0] spd_drag;
  logic signed [16:0] spd_after;
  always_comb begin
    spd_drag = 42'(spd_q);
    if (spd_q > 0) begin
      spd_drag = 42'(spd_q) - $signed({2'b0, drag_q});
      if (spd_drag < 0) spd_drag = '0;
    end else if (spd_q < 0) begin
      spd_drag = 42'(spd_q) + $signed({2'b0, drag_q});
      if (spd_drag > 0) spd_drag = '0;
    end
    spd_after = 17'(spd_drag);
  end

  logic pow_ok;
  assign pow_ok = master_q && (eng_q != '0) &&
    ((dir_q == 2'b01 && spd_after > 0) || (dir_q == 2'b11 && spd_after < 0) ||
     (spd_after < 17'sd128 && spd_after > -17'sd128));

  logic signed [18:0] spd_push;
  always_comb begin
    spd_push = 19'(spd_after);
    if (dir_q == 2'b01) spd_push = 19'(spd_after) + 19'(sq_root[19:4]);
    else if (dir_q == 2'b11) spd_push = 19'(spd_after) - 19'(sq_root[19:4]);
  end

  logic signed [16:0] spd_clamp;
  always_comb begin
    if (spd_push > 19'sd25600) spd_clamp = 17'sd25600;
    else if (spd_push < -19'sd25600) spd_clamp = -17'sd25600;
    else spd_clamp = spd_push[16:0];
  end

  logic [40:0] smk_sum;
  assign smk_sum = {1'b0, smk_q} + 41'(mprod[59:20]);

  // result register loads when free or being emptied
  logic out_load;
  assign out_load = (state_q == StDone) && (!out_valid_q || m_axis_tready);

  always_comb begin
    mreq     = '0;
    sq_start = 1'b0;
    sq_rad   = '0;
    unique case (state_q)
      StIdle: if (acc) begin
        mreq.start = 1'b1; mreq.mcand = 40'(mag); mreq.mplier = 40'(mag);
      end
      StAir1: if (mdone) begin
        mreq.start = 1'b1; mreq.mcand = mprod[39:0]; mreq.mplier = 40'(air_q);
      end
      StAir2: if (mdone) begin
        mreq.start = 1'b1; mreq.mcand = 40'(brk_gain_q); mreq.mplier = 40'(brk_q);
      end
      StBrake: ;
      StDrag: if (pow_ok) begin
        mreq.start = 1'b1; mreq.mcand = 40'(pow_q); mreq.mplier = 40'(eng_q);
      end
      StPow: if (mdone) begin
        sq_start = 1'b1; sq_rad = mprod[39:0];
      end
      StPowSq: ;
      StSmk1: if (eon_q && thr_q > eng_q) begin
        mreq.start = 1'b1; mreq.mcand = 40'(sthr_q); mreq.mplier = 40'(thr_q - eng_q);
      end
      StSmk2: if (mdone || !(thr_q > eng_q)) begin
        sq_start = 1'b1; sq_rad = {9'd0, eng_q, 16'd0};
      end
      StSmkSq: if (sq_done) begin
        mreq.start = 1'b1; mreq.mcand = 40'(swrk_q); mreq.mplier = 40'(sq_root);
      end
      StSmk3: ;
      StDone: ;
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spinup_q <= 15'd256; air_q <= '0; roll_q <= '0; brk_gain_q <= '0;
      pow_q <= '0; sthr_q <= '0; swrk_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSpinup:       spinup_q   <= cfg_data_i[14:0];
        CfgAirDrag:      air_q      <= cfg_data_i;
        CfgRollDrag:     roll_q     <= cfg_data_i[14:0];
        CfgBrakeGain:    brk_gain_q <= cfg_data_i;
        CfgPowerGain:    pow_q      <= cfg_data_i;
        CfgSmokeThrGain: sthr_q     <= cfg_data_i;
        CfgSmokeWrkGain: swrk_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // tick sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; eon_q <= 1'b0; eng_q <= '0; spd_q <= '0;
      out_valid_q <= 1'b0; out_data_q <= '0;
      thr_q <= '0; brk_q <= '0; dir_q <= '0; master_q <= 1'b0;
      drag_q <= '0; smk_q <= '0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (acc) begin
          thr_q <= in_thr; brk_q <= s_axis_tdata[29:15];
          dir_q <= s_axis_tdata[31:30]; master_q <= in_master;
          eon_q <= eon_new; eng_q <= eng_new;
          state_q <= StAir1;
        end
        StAir1: if (mdone) state_q <= StAir2;
        StAir2: if (mdone) begin
          drag_q  <= 40'(mprod[79:24]) + 40'(roll_q);
          state_q <= StBrake;
        end
        StBrake: if (mdone) begin
          drag_q  <= drag_q + 40'(mprod[79:16]);
          state_q <= StDrag;
        end
        StDrag: begin
          if (pow_ok) state_q <= StPow;
          else begin
            spd_q   <= (spd_after > 17'sd25600) ? 17'sd25600 :
                       (spd_after < -17'sd25600) ? -17'sd25600 : spd_after;
            state_q <= StSmk1;
          end
        end
        StPow: if (mdone) state_q <= StPowSq;
        StPowSq: if (sq_done) begin
          spd_q <= spd_clamp; state_q <= StSmk1;
        end
        StSmk1: begin
          smk_q <= '0;
          state_q <= eon_q ? StSmk2 : StDone;
        end
        StSmk2: if (mdone || !(thr_q > eng_q)) begin
          if (mdone) smk_q <= mprod[55:16];
          state_q <= StSmkSq;
        end
        StSmkSq: if (sq_done) state_q <= StSmk3;
        StSmk3: if (mdone) begin
          smk_q   <= (smk_sum > 41'(FullScale)) ? 40'(FullScale) : smk_sum[39:0];
          state_q <= StDone;
        end
        StDone: if (out_load) begin
          out_data_q  <= {1'b0, eon_q, smk_q[14:0], eng_q, spd_q[15:0]};
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  // output holds the engine flag of the state
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> out_data_q[46] == eon_q) else $error("flag mismatch");
  // engine level never exceeds full scale
  a_eng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_q <= 15'(FullScale)) else $error("engine over range");
  // engine off means smoke reported zero
  a_smk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && !eon_q |-> out_data_q[45:31] == '0) else $error("smoke when off");
`endif

endmodule

>>> bench/testbench.sv
// Self-checking bench for the locomotive momentum step core.
module testbench;
  import lms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CmdNone = 2'd0;
  localparam logic [1:0] CmdOdd  = 2'd3;
  localparam logic [1:0] DirFwd  = 2'b01;
  localparam logic [1:0] DirRev  = 2'b11;
  localparam logic [1:0] DirNeu  = 2'b00;
  localparam logic [1:0] DirOdd  = 2'b10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        master;
    logic [1:0]  dir;
    logic [14:0] brake;
    logic [14:0] throttle;
  } tick_t;

  typedef struct packed {
    logic        running;
    logic [14:0] smoke;
    logic [14:0] engine;
    logic [15:0] speed;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  locomotive_momentum_step_core DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state and register copies
  logic [23:0] gain_q [7];
  logic        eng_on_q;
  longint      eng_q, spd_q;
  status_t     expected_status [$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_cycles = 0;
  int          held_cycles = 0;

  function automatic longint isqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // Advance the physics state by one tick, queue the status it produces
  task automatic predict_tick(tick_t t);
    longint thr = t.throttle, brk = t.brake, s = gain_q[CfgSpinup];
    longint dir, e = eng_q, v = spd_q, mag, drag, smoke = 0;
    longint full = longint'(FullScale), band = longint'(StandstillBand);
    status_t r;
    dir = (t.dir == DirFwd) ? 1 : (t.dir == DirRev) ? -1 : 0;
    if (t.cmd == CmdStart) eng_on_q = t.master;
    else if (t.cmd == CmdStop) eng_on_q = 1'b0;
    if (!t.master) eng_on_q = 1'b0;
    if (eng_on_q) begin
      if (2 * e < 2 * thr - s) e += s;
      else if (2 * e > 2 * thr + s) e -= s;
    end else begin
      e -= s;
    end
    if (e > full) e = full;
    else if (e < 0) e = 0;
    mag = v < 0 ? -v : v;
    drag = (longint'(gain_q[CfgAirDrag]) * mag * mag) >>> 24;
    drag += gain_q[CfgRollDrag];
    drag += (longint'(gain_q[CfgBrakeGain]) * brk) >>> 16;
    if (v > 0) begin
      v -= drag;
      if (v < 0) v = 0;
    end else if (v < 0) begin
      v += drag;
      if (v > 0) v = 0;
    end
    if (t.master && e > 0 && (v * dir > 0 || (v < band && v > -band)))
      v += dir * (isqrt(longint'(gain_q[CfgPowerGain]) * e) >>> 4);
    if (v > full) v = full;
    else if (v < -full) v = -full;
    if (eng_on_q) begin
      if (thr > e) smoke += (longint'(gain_q[CfgSmokeThrGain]) * (thr - e)) >>> 16;
      smoke += (longint'(gain_q[CfgSmokeWrkGain]) * isqrt(e << 16)) >>> 20;
    end
    if (smoke > full) smoke = full;
    eng_q = e;
    spd_q = v;
    r.speed = v[15:0];
    r.engine = e[14:0];
    r.smoke = smoke[14:0];
    r.running = eng_on_q;
    expected_status.push_back(r);
  endtask

  // Send one tick transaction; valid stays up until the next call or a drain
  task automatic send_tick(tick_t t);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {5'd0, t};
    s_axis_tvalid <= 1'b1;
    predict_tick(t);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  // Write enable stays up across a burst; set_gains drops it
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    gain_q[idx] = (idx == CfgSpinup || idx == CfgRollDrag) ? {9'd0, val[14:0]} : val;
    @(negedge clk_i);
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    t.throttle = ($urandom_range(15) == 0) ? 15'($urandom) : 15'($urandom_range(25600));
    t.brake = ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(3000));
    t.dir = ($urandom_range(9) == 0) ? 2'($urandom) :
            ($urandom_range(2) == 0 ? DirRev : DirFwd);
    t.master = ($urandom_range(19) != 0);
    t.cmd = ($urandom_range(9) == 0) ? 2'($urandom) : CmdNone;
    return t;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    status_t got, exp_s;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[46:0];
      if (m_axis_tdata[47] !== 1'b0) begin
        $display("%0t: pad bit expected 0 actual %b", $time, m_axis_tdata[47]);
        errors++;
      end
      if (expected_status.size() == 0) begin
        $display("%0t: status expected none actual %h", $time, got);
        errors++;
      end else begin
        exp_s = expected_status.pop_front();
        if (got.speed !== exp_s.speed) begin
          $display("%0t: speed expected %0d actual %0d", $time,
                   $signed(exp_s.speed), $signed(got.speed));
          errors++;
        end
        if (got.engine !== exp_s.engine) begin
          $display("%0t: engine expected %0d actual %0d", $time, exp_s.engine, got.engine);
          errors++;
        end
        if (got.smoke !== exp_s.smoke) begin
          $display("%0t: smoke expected %0d actual %0d", $time, exp_s.smoke, got.smoke);
          errors++;
        end
        if (got.running !== exp_s.running) begin
          $display("%0t: running expected %b actual %b", $time, exp_s.running, got.running);
          errors++;
        end
      end
    end
  end

  // Receiver ready, with random stalls and long hold-offs
  always @(negedge clk_i) begin
    if (held_cycles < hold_off_cycles) begin
      held_cycles <= held_cycles + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Extremes, every command, odd encodings, master-off handling
  task automatic test_directed();
    send_tick('{cmd: CmdStart, master: 1'b0, dir: DirFwd, brake: 0, throttle: 25600});
    send_tick('{cmd: CmdStart, master: 1'b1, dir: DirFwd, brake: 0, throttle: 25600});
    repeat (4) send_tick('{cmd: CmdNone, master: 1'b1, dir: DirFwd, brake: 0, throttle: 25600});
    send_tick('{cmd: CmdOdd, master: 1'b1, dir: DirFwd, brake: 0, throttle: 15'h7fff});
    send_tick('{cmd: CmdNone, master: 1'b1, dir: DirOdd, brake: 15'h7fff, throttle: 100});
    send_tick('{cmd: CmdNone, master: 1'b1, dir: DirRev, brake: 0, throttle: 25600});
    send_tick('{cmd: CmdStop, master: 1'b1, dir: DirFwd, brake: 0, throttle: 0});
    send_tick('{cmd: CmdNone, master: 1'b1, dir: DirFwd, brake: 0, throttle: 0});
    send_tick('{cmd: CmdStart, master: 1'b1, dir: DirNeu, brake: 25600, throttle: 12800});
    send_tick('{cmd: CmdNone, master: 1'b0, dir: DirFwd, brake: 0, throttle: 25600});
    send_tick('{cmd: CmdStart, master: 1'b1, dir: DirRev, brake: 0, throttle: 25600});
    repeat (6) send_tick('{cmd: CmdNone, master: 1'b1, dir: DirRev, brake: 0, throttle: 25600});
    send_tick('{cmd: CmdNone, master: 1'b1, dir: DirFwd, brake: 25600, throttle: 0});
    drain();
  endtask

  task automatic test_random(int n, int sidle, int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (n) send_tick(rand_tick());
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
  endtask

  // Receiver blocked for a long stretch while ticks keep coming
  task automatic test_backpressure();
    @(negedge clk_i);
    hold_off_cycles = 3000;
    repeat (6) send_tick(rand_tick());
    drain();
    repeat (5) send_tick(rand_tick());
    drain();
  endtask

  task automatic set_gains(logic [23:0] sp, logic [23:0] air, logic [23:0] roll,
                           logic [23:0] brk, logic [23:0] pwr, logic [23:0] st,
                           logic [23:0] sw);
    write_reg(CfgSpinup, sp);
    write_reg(CfgAirDrag, air);
    write_reg(CfgRollDrag, roll);
    write_reg(CfgBrakeGain, brk);
    write_reg(CfgPowerGain, pwr);
    write_reg(CfgSmokeThrGain, st);
    write_reg(CfgSmokeWrkGain, sw);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    gain_q = '{24'd256, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
    eng_on_q = 1'b0;
    eng_q = 0;
    spd_q = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    set_gains(24'd512, 24'd40, 24'd10, 24'd8000, 24'd2000000, 24'd30000, 24'd90000);
    test_directed();
    test_random(120, 0, 0);
    set_gains(24'd25600, 24'hffffff, 24'd25600, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
    test_random(40, 73, 0);
    set_gains(24'h7fff, 24'd0, 24'h7fff, 24'd0, 24'hffffff, 24'd1, 24'd1);
    test_random(40, 0, 73);
    set_gains(24'd0, 24'd1, 24'd0, 24'd1, 24'd1, 24'd0, 24'd0);
    test_random(30, 29, 29);
    set_gains(24'd300, 24'd20, 24'd5, 24'd3000, 24'd8000000, 24'd60000, 24'd200000);
    test_random(120, 73, 0);
    test_random(120, 0, 73);
    test_backpressure();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
